/* rtl/amad_pkg.sv */
package amad_pkg;

	// Default sizes of the mix store.
	localparam int DEFAULT_STORE_DEPTH = 1024;
	localparam int DEFAULT_ACC_WIDTH   = 20;

	// Field widths of the stream words.
	localparam int SAMPLE_W = 16;
	localparam int OFS_W    = 10;
	localparam int STRIDE_W = 4;
	localparam int PCM_W    = 16;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 4'd1;

	// Command codes carried in the input tuser.
	localparam logic CMD_MIX   = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Full scale in Q.15, the clamp limit of a drained entry.
	localparam int Q15_ONE = 32768;

	// Result queue between the drain stage and the output port.
	localparam int RES_FIFO_DEPTH = 3;
	localparam int RES_PTR_W      = 2;
	localparam int RES_CNT_W      = 2;

	typedef struct packed {
		logic [PCM_W-1:0] pcm;
		logic             last;
		logic             empty_res;
	} result_t;

endpackage

/* rtl/amad_mix_ram.sv */
module amad_mix_ram #(
	parameter int DEPTH = amad_pkg::DEFAULT_STORE_DEPTH,
	parameter int WIDTH = amad_pkg::DEFAULT_ACC_WIDTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/amad_result_fifo.sv */
module amad_result_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  amad_pkg::result_t                   push_data,
	input  logic                                pop,
	output amad_pkg::result_t                   head,
	output logic                                head_valid,
	output logic [amad_pkg::RES_CNT_W-1:0]      count
);

	amad_pkg::result_t                entry_q [amad_pkg::RES_FIFO_DEPTH];
	logic [amad_pkg::RES_PTR_W-1:0]   rd_ptr_q;
	logic [amad_pkg::RES_PTR_W-1:0]   wr_ptr_q;
	logic [amad_pkg::RES_CNT_W-1:0]   count_q;
	logic                             do_pop;

	assign do_pop     = pop && (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign count      = count_q;

	function automatic logic [amad_pkg::RES_PTR_W-1:0] ptr_next(
		input logic [amad_pkg::RES_PTR_W-1:0] p
	);
		logic [amad_pkg::RES_PTR_W-1:0] n;
		if (p == amad_pkg::RES_PTR_W'(amad_pkg::RES_FIFO_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + amad_pkg::RES_PTR_W'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + amad_pkg::RES_CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - amad_pkg::RES_CNT_W'(1);
			end
		end
	end

	// The upstream admission rule must never push into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != amad_pkg::RES_CNT_W'(amad_pkg::RES_FIFO_DEPTH)))
		else $error("result queue pushed while full");

endmodule

/* rtl/audio_mix_accumulate_and_drain.sv */
// Mix word: the store entry is read in the accept cycle and written back in the following cycle.
// Drain word: it passes the write-back stage and its result joins the queue that drives m_tvalid.
// Throughput is one word per cycle for mixes and drains alike while s_tready is high, set by the single
// read-modify-write per word on the store, with write-back forwarding and a three-entry result queue.
// After reset a clearing pass zeroes the store entry by entry (STORE_DEPTH entries, 1024 by default);
// s_tready stays low during the pass, while stride writes are taken at any time.
module audio_mix_accumulate_and_drain #(
	parameter int STORE_DEPTH = amad_pkg::DEFAULT_STORE_DEPTH,
	parameter int ACC_WIDTH   = amad_pkg::DEFAULT_ACC_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Stride register write port.
	input  logic                          dest_stride_we,
	input  logic [amad_pkg::STRIDE_W-1:0] dest_stride_wdata,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,  // sample [15:0], write_offset [25:16], zero [31:26]
	input  logic [1:0]                    s_tuser,  // cmd [0], first [1]
	// Output stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [amad_pkg::PCM_W-1:0]    m_tdata,  // pcm [15:0]
	output logic                          m_tlast,  // last
	output logic [0:0]                    m_tuser   // empty_res [0]
);

	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int UC_W = AW + 1;
	// The write position must hold the store depth and any offset value.
	localparam int WP_W = (UC_W > amad_pkg::OFS_W) ? UC_W : amad_pkg::OFS_W;

	// Control of the word in the write-back stage.
	typedef struct packed {
		logic valid;
		logic mix;
		logic drain;
		logic empty;
		logic last;
	} s1_ctrl_t;

	// Input word fields.
	logic                                 in_cmd;
	logic                                 in_first;
	logic signed [amad_pkg::SAMPLE_W-1:0] in_sample;
	logic [amad_pkg::OFS_W-1:0]           in_offset;
	logic                                 in_accept;
	logic                                 in_is_drain;

	// Scalar state.
	logic [amad_pkg::STRIDE_W-1:0] stride_q;
	logic [WP_W-1:0]               wp_q;
	logic [UC_W-1:0]               used_q;
	logic [AW-1:0]                 dp_q;
	logic                          clr_active_q;
	logic [AW-1:0]                 clr_addr_q;

	// Accept-cycle decisions.
	logic [WP_W-1:0] mix_pos;
	logic            mix_in_range;
	logic [WP_W:0]   wp_sum;
	logic [WP_W-1:0] wp_next;
	logic [UC_W-1:0] mix_used;
	logic            store_empty;
	logic [UC_W-1:0] dp_inc;
	logic            drain_last;
	logic [AW-1:0]   rd_addr;

	// Write-back stage.
	s1_ctrl_t                             ctrl_s1;
	logic [AW-1:0]                        addr_s1;
	logic signed [amad_pkg::SAMPLE_W-1:0] sample_s1;
	logic signed [ACC_WIDTH-1:0]          rd_data;
	logic signed [ACC_WIDTH-1:0]          old_val;
	logic                                 fwd_valid_q;
	logic [AW-1:0]                        fwd_addr_q;
	logic signed [ACC_WIDTH-1:0]          fwd_data_q;
	logic signed [ACC_WIDTH:0]            sum_wide;
	logic signed [ACC_WIDTH-1:0]          sum_sat;
	logic signed [32:0]                   old_ext;
	logic signed [16:0]                   clamp_val;
	logic signed [31:0]                   clamp_ext;
	logic signed [31:0]                   scaled;
	logic signed [16:0]                   scaled_q;
	logic [14:0]                          scaled_rem;
	logic                                 round_up;
	logic signed [16:0]                   rounded;

	// Store write port.
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic signed [ACC_WIDTH-1:0] mem_wdata;

	// Result queue.
	logic                           res_push;
	amad_pkg::result_t              res_in;
	amad_pkg::result_t              res_head;
	logic [amad_pkg::RES_CNT_W-1:0] res_count;
	logic                           room_ok;

	assign in_cmd      = s_tuser[0];
	assign in_first    = s_tuser[1];
	assign in_sample   = s_tdata[15:0];
	assign in_offset   = s_tdata[25:16];
	assign in_accept   = s_tvalid && s_tready;
	assign in_is_drain = (in_cmd == amad_pkg::CMD_DRAIN);

	// A word is admitted only when the result queue can still take every drain
	// result that is queued, in flight, or carried by this word.
	assign room_ok  = ((3'(res_count) + 3'(res_push)) <= 3'(amad_pkg::RES_FIFO_DEPTH - 1));
	assign s_tready = !clr_active_q && room_ok;

	// The first sample of a write restarts at its offset; otherwise the
	// position continues. Positions past the end drop the sample.
	always_comb begin
		mix_pos      = in_first ? WP_W'(in_offset) : wp_q;
		mix_in_range = (mix_pos < WP_W'(STORE_DEPTH));
		wp_sum       = {1'b0, mix_pos} + (WP_W + 1)'(stride_q);
		if (wp_sum > (WP_W + 1)'(STORE_DEPTH)) begin
			wp_next = WP_W'(STORE_DEPTH);
		end else begin
			wp_next = wp_sum[WP_W-1:0];
		end
		mix_used = {1'b0, mix_pos[AW-1:0]} + UC_W'(1);
	end

	// The drain pointer always stays below the used count while the store is
	// in use, so the drained entry is valid whenever the count is nonzero.
	assign store_empty = (used_q == '0);
	assign dp_inc      = {1'b0, dp_q} + UC_W'(1);
	assign drain_last  = (dp_inc >= used_q);
	assign rd_addr     = in_is_drain ? dp_q : mix_pos[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q     <= amad_pkg::STRIDE_RESET;
			wp_q         <= '0;
			used_q       <= '0;
			dp_q         <= '0;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			ctrl_s1      <= '0;
			fwd_valid_q  <= 1'b0;
		end else begin
			if (dest_stride_we) begin
				stride_q <= dest_stride_wdata;
			end

			// The clearing pass walks the store once after reset.
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(STORE_DEPTH - 1)) begin
					clr_active_q <= 1'b0;
				end
			end

			if (in_accept) begin
				if (!in_is_drain) begin
					wp_q <= wp_next;
					if (mix_in_range && (used_q < mix_used)) begin
						used_q <= mix_used;
					end
				end else if (!store_empty) begin
					if (drain_last) begin
						used_q <= '0;
						dp_q   <= '0;
					end else begin
						dp_q <= dp_inc[AW-1:0];
					end
				end
			end

			ctrl_s1.valid <= in_accept && (in_is_drain || mix_in_range);
			ctrl_s1.mix   <= !in_is_drain && mix_in_range;
			ctrl_s1.drain <= in_is_drain && !store_empty;
			ctrl_s1.empty <= in_is_drain && store_empty;
			ctrl_s1.last  <= in_is_drain && !store_empty && drain_last;

			fwd_valid_q <= mem_we;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= rd_addr;
		sample_s1  <= in_sample;
		fwd_addr_q <= mem_waddr;
		fwd_data_q <= mem_wdata;
	end

	amad_mix_ram #(
		.DEPTH(STORE_DEPTH),
		.WIDTH(ACC_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// The store returns the old contents when the previous word wrote the same
	// entry in the cycle of this read, so the last write is forwarded.
	assign old_val = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rd_data;

	// Saturating add of the sample into the accumulator.
	always_comb begin
		sum_wide = (ACC_WIDTH + 1)'(old_val) + (ACC_WIDTH + 1)'(sample_s1);
		if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1]) begin
			sum_sat = sum_wide[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH - 1){1'b0}}}
			                              : {1'b0, {(ACC_WIDTH - 1){1'b1}}};
		end else begin
			sum_sat = sum_wide[ACC_WIDTH-1:0];
		end
	end

	// Drain scaling: clamp to plus or minus one, multiply by 32767/32768 as a
	// shift and subtract, then round to nearest with ties to even.
	always_comb begin
		old_ext = 33'(old_val);
		if (old_ext > 33'(amad_pkg::Q15_ONE)) begin
			clamp_val = 17'(amad_pkg::Q15_ONE);
		end else if (old_ext < -33'(amad_pkg::Q15_ONE)) begin
			clamp_val = -17'(amad_pkg::Q15_ONE);
		end else begin
			clamp_val = old_ext[16:0];
		end
		clamp_ext  = 32'(clamp_val);
		scaled     = (clamp_ext <<< 15) - clamp_ext;
		scaled_q   = scaled[31:15];
		scaled_rem = scaled[14:0];
		round_up   = (scaled_rem > 15'h4000) || ((scaled_rem == 15'h4000) && scaled_q[0]);
		rounded    = scaled_q + 17'(round_up);
	end

	// The clearing pass zeroes the store; after it, mixes store the saturated sum and drains leave a zero behind.
	always_comb begin
		if (clr_active_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = ctrl_s1.valid && (ctrl_s1.mix || ctrl_s1.drain);
			mem_waddr = addr_s1;
			mem_wdata = ctrl_s1.mix ? sum_sat : '0;
		end
	end

	assign res_push = ctrl_s1.valid && (ctrl_s1.drain || ctrl_s1.empty);

	always_comb begin
		res_in.pcm       = ctrl_s1.empty ? '0 : rounded[15:0];
		res_in.last      = ctrl_s1.last;
		res_in.empty_res = ctrl_s1.empty;
	end

	amad_result_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_in),
		.pop       (m_tready),
		.head      (res_head),
		.head_valid(m_tvalid),
		.count     (res_count)
	);

	assign m_tdata    = res_head.pcm;
	assign m_tlast    = res_head.last;
	assign m_tuser[0] = res_head.empty_res;

	// No word may reach the write-back stage while the clearing pass owns the store.
	a_clear_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !ctrl_s1.valid)
		else $error("word in flight during clearing pass");

	// The used count never exceeds the store depth.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UC_W'(STORE_DEPTH))
		else $error("used count beyond store depth");

	// An empty store has its drain pointer at the start.
	a_empty_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q == '0) |-> (dp_q == '0))
		else $error("drain pointer nonzero on empty store");

	// Every accepted drain produces exactly one queued result in the next cycle.
	a_drain_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_is_drain) |=> res_push)
		else $error("drain word produced no result");

endmodule
